// ----- sv/interval_histogram_percentile_top_defines.svh -----
// assertion macros for the interval histogram checker
// needs clk and rst in scope at the point of use
`ifndef INTERVAL_HISTOGRAM_PERCENTILE_TOP_DEFINES_SVH
`define INTERVAL_HISTOGRAM_PERCENTILE_TOP_DEFINES_SVH

// same-cycle implication
`define IHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ihp_pkg.sv -----
// shared types and codes for the interval histogram
// no dependencies
`default_nettype none

package ihp_pkg;

  // quotient bits kept by the binning divider (bins_in_use is 7 bits)
  localparam int QW = 7;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REPORT = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [2:0] ST_BINNED  = 3'd0;
  localparam logic [2:0] ST_BELOW   = 3'd1;
  localparam logic [2:0] ST_ABOVE   = 3'd2;
  localparam logic [2:0] ST_REPORT  = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_SCALE  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BINS   = 3'd3;
  localparam logic [2:0] REG_LPCT   = 3'd4;
  localparam logic [2:0] REG_UPCT   = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] bin_total;
    logic [31:0] interval_count;
    logic [6:0]  lower_bin;
    logic [6:0]  upper_bin;
    logic [31:0] below_delta;
    logic [31:0] above_delta;
    logic [31:0] total_count;
  } result_t;

  // outcome of the bin calculation
  typedef struct packed {
    logic          below;
    logic          above;
    logic [QW-1:0] idx;
  } bin_res_t;

endpackage

`default_nettype wire

// ----- sv/ihp_bin_calc.sv -----
// bin index calculation: offset, split multiply and short restoring divide
// depends on ihp_pkg
`default_nettype none

module ihp_bin_calc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [31:0] sample,
  input  wire logic signed [31:0] offset,
  input  wire logic [19:0]        scale,
  input  wire logic [15:0]        width,
  input  wire logic [6:0]         nact,
  output logic                    done,
  output ihp_pkg::bin_res_t       res
);
  import ihp_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_MLO, C_MHI, C_ACC, C_CHK, C_DIV} cstate_t;

  cstate_t       state;
  logic [32:0]   mag;
  logic          neg;
  logic [52:0]   prod;
  logic [35:0]   ph;
  logic [15:0]   wd;
  logic [22:0]   rem;
  logic [22:0]   dv;
  logic [QW-1:0] q;
  logic [2:0]    step;

  logic [32:0]   diff;
  logic [36:0]   pl;
  logic          ge;
  logic [QW-1:0] q_next;
  logic          q_below;

  // sample minus offset, sign-extended to 33 bits
  assign diff    = {sample[31], sample} - {offset[31], offset};
  assign pl      = 37'(scale) * 37'(mag[16:0]);
  assign ge      = (rem >= dv);
  assign q_next  = {q[QW-2:0], ge};
  assign q_below = neg && (q_next != '0);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (go) begin
            neg   <= diff[32];
            mag   <= diff[32] ? (~diff + 33'd1) : diff;
            wd    <= (width == 16'd0) ? 16'd1 : width;
            state <= C_MLO;
          end
        end
        // low partial product
        C_MLO: begin
          prod  <= {16'b0, pl};
          state <= C_MHI;
        end
        // high partial product
        C_MHI: begin
          ph    <= 36'(scale) * 36'(mag[32:17]);
          state <= C_ACC;
        end
        C_ACC: begin
          prod  <= prod + {ph, 17'b0};
          state <= C_CHK;
        end
        // quotient of 128 or more is out of range either way
        C_CHK: begin
          if (prod >= {30'b0, wd, 7'b0}) begin
            res.below <= neg;
            res.above <= !neg;
            res.idx   <= '0;
            done      <= 1'b1;
            state     <= C_IDLE;
          end else begin
            rem   <= prod[22:0];
            dv    <= {1'b0, wd, 6'b0};
            q     <= '0;
            step  <= 3'd0;
            state <= C_DIV;
          end
        end
        // one quotient bit a cycle
        C_DIV: begin
          q    <= q_next;
          rem  <= ge ? (rem - dv) : rem;
          dv   <= dv >> 1;
          step <= step + 3'd1;
          if (step == 3'(QW - 1)) begin
            res.below <= q_below;
            res.above <= !q_below && (q_next >= nact);
            res.idx   <= q_next;
            done      <= 1'b1;
            state     <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/interval_histogram_percentile_top.sv -----
// interval histogram top level: control, counters and the two bin memories
// depends on ihp_pkg and ihp_bin_calc
`default_nettype none

// Latency histogram with interval percentiles. Raise start with a command
// while busy is low; the single result appears on result for one cycle with
// done high and cannot be held off. After reset the block sweeps both bin
// memories with busy high. An insert forms two partial products of the scale
// multiply, then, unless the quotient is 128 or more, seven divide steps for
// the bin index, then, for an in-range bin, a read-modify-write of the bin
// counter. A report walks the active bins through the count and snapshot
// memories one bin a cycle. A clear sweeps the count memory. Command code 3
// is taken and produces no result.
module interval_histogram_percentile_top #(
  parameter int BINS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ihp_pkg::cmd_t    cmd,
  output logic                  busy,
  output logic                  done,
  output ihp_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);
  import ihp_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    T_SWEEP, T_IDLE, T_NOP, T_BIN, T_INC, T_RPREP, T_WALK
  } tstate_t;

  tstate_t state;

  // configuration
  logic signed [31:0] sample_offset;
  logic [19:0]        unit_scale;
  logic [15:0]        bin_width;
  logic [6:0]         bins_in_use;
  logic [6:0]         lower_pct;
  logic [6:0]         upper_pct;

  // scalar counters
  logic [31:0] population, below_count, above_count;
  logic [31:0] population_snapshot, below_snapshot, above_snapshot;

  logic          clr_all;
  logic [AW-1:0] swp;
  logic [AW-1:0] inc_idx;

  // report walk
  logic [38:0]   lthr, uthr;
  logic [45:0]   run100;
  logic          lf, uf;
  logic [AW-1:0] lbin, ubin;
  logic [CW-1:0] iss;
  logic          v1, v2, pos2;
  logic [AW-1:0] ix1, ix2;
  logic [38:0]   d100;

  // memories
  logic [31:0]   cnt_mem [BINS];
  logic [31:0]   snp_mem [BINS];
  logic          cnt_we, snp_we;
  logic [AW-1:0] cnt_wa, snp_wa, cnt_ra, snp_ra;
  logic [31:0]   cnt_wd, snp_wd, cnt_rd, snp_rd;

  logic          accept;
  logic          calc_go, calc_done;
  bin_res_t      calc_res;
  logic [6:0]    nact;
  logic [CW-1:0] n_c;
  logic [31:0]   pop_inc;
  logic [31:0]   d1;
  logic          pos1;
  logic [45:0]   sum;
  logic          walk_end;

  assign accept   = start && !busy;
  assign busy     = (state != T_IDLE);
  assign calc_go  = accept && (cmd.func == FN_INSERT);
  assign nact     = ({25'b0, bins_in_use} > 32'(BINS)) ? 7'(BINS) : bins_in_use;
  assign n_c      = CW'(nact);
  assign pop_inc  = population + 32'd1;
  assign d1       = cnt_rd - snp_rd;
  assign pos1     = (d1 != 32'd0) && !d1[31];
  assign sum      = run100 + {7'b0, d100};
  assign walk_end = (iss == n_c) && !v1 && !v2;

  ihp_bin_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .go     (calc_go),
    .sample (cmd.sample),
    .offset (sample_offset),
    .scale  (unit_scale),
    .width  (bin_width),
    .nact   (nact),
    .done   (calc_done),
    .res    (calc_res)
  );

  // memory port control
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = swp;
    cnt_wd = '0;
    cnt_ra = iss[AW-1:0];
    snp_we = 1'b0;
    snp_wa = swp;
    snp_wd = '0;
    snp_ra = iss[AW-1:0];
    case (state)
      T_SWEEP: begin
        cnt_we = 1'b1;
        snp_we = clr_all;
      end
      T_BIN: cnt_ra = AW'(calc_res.idx);
      T_INC: begin
        cnt_we = 1'b1;
        cnt_wa = inc_idx;
        cnt_wd = cnt_rd + 32'd1;
      end
      T_WALK: begin
        snp_we = v1 && pos1;
        snp_wa = ix1;
        snp_wd = cnt_rd;
      end
      default: ;
    endcase
  end

  // bin counter memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  // bin snapshot memory
  always_ff @(posedge clk) begin
    if (snp_we) begin
      snp_mem[snp_wa] <= snp_wd;
    end
    snp_rd <= snp_mem[snp_ra];
  end

  // control, counters and result register
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state               <= T_SWEEP;
      clr_all             <= 1'b1;
      swp                 <= '0;
      v1                  <= 1'b0;
      v2                  <= 1'b0;
      population          <= '0;
      below_count         <= '0;
      above_count         <= '0;
      population_snapshot <= '0;
      below_snapshot      <= '0;
      above_snapshot      <= '0;
      sample_offset       <= '0;
      unit_scale          <= 20'd1;
      bin_width           <= 16'd1;
      bins_in_use         <= 7'd64;
      lower_pct           <= 7'd5;
      upper_pct           <= 7'd95;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET: sample_offset <= cfg_data;
          REG_SCALE:  unit_scale    <= cfg_data[19:0];
          REG_WIDTH:  bin_width     <= cfg_data[15:0];
          REG_BINS:   bins_in_use   <= cfg_data[6:0];
          REG_LPCT:   lower_pct     <= cfg_data[6:0];
          REG_UPCT:   upper_pct     <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        // zero the count memory, and after reset also the snapshot memory, one entry a cycle
        T_SWEEP: begin
          swp <= swp + AW'(1);
          if (swp == AW'(BINS - 1)) begin
            state <= T_IDLE;
            if (!clr_all) begin
              result.status      <= ST_CLEARED;
              result.total_count <= population;
              done               <= 1'b1;
            end
          end
        end
        T_IDLE: begin
          if (accept) begin
            case (cmd.func)
              FN_INSERT: begin
                result <= '0;
                state  <= T_BIN;
              end
              FN_REPORT: begin
                result <= '{interval_count: population - population_snapshot,
                            below_delta:    below_count - below_snapshot,
                            above_delta:    above_count - above_snapshot,
                            default:        '0};
                population_snapshot   <= population;
                below_snapshot        <= below_count;
                above_snapshot        <= above_count;
                state                 <= T_RPREP;
              end
              FN_CLEAR: begin
                result  <= '0;
                clr_all <= 1'b0;
                swp     <= '0;
                state   <= T_SWEEP;
              end
              default: begin
                result <= '0;
                state  <= T_NOP;
              end
            endcase
          end
        end
        T_NOP: state <= T_IDLE;
        // wait for the bin index
        T_BIN: begin
          if (calc_done) begin
            if (calc_res.below || calc_res.above) begin
              population         <= pop_inc;
              result.total_count <= pop_inc;
              done               <= 1'b1;
              state              <= T_IDLE;
              if (calc_res.below) begin
                below_count   <= below_count + 32'd1;
                result.status <= ST_BELOW;
              end else begin
                above_count   <= above_count + 32'd1;
                result.status <= ST_ABOVE;
              end
            end else begin
              inc_idx <= AW'(calc_res.idx);
              state   <= T_INC;
            end
          end
        end
        // counter read data is here, write back the increment
        T_INC: begin
          population         <= pop_inc;
          result.status      <= ST_BINNED;
          result.bin_total   <= cnt_rd + 32'd1;
          result.total_count <= pop_inc;
          done               <= 1'b1;
          state              <= T_IDLE;
        end
        // percentile thresholds
        T_RPREP: begin
          lthr   <= 39'(lower_pct) * 39'(result.interval_count);
          uthr   <= 39'(upper_pct) * 39'(result.interval_count);
          run100 <= '0;
          lf     <= 1'b0;
          uf     <= 1'b0;
          lbin   <= '0;
          ubin   <= '0;
          iss    <= '0;
          v1     <= 1'b0;
          v2     <= 1'b0;
          state  <= T_WALK;
        end
        // read, delta and accumulate stages over the active bins
        T_WALK: begin
          if (iss != n_c) begin
            v1  <= 1'b1;
            ix1 <= iss[AW-1:0];
            iss <= iss + CW'(1);
          end else begin
            v1 <= 1'b0;
          end
          v2   <= v1;
          pos2 <= v1 && pos1;
          d100 <= 39'(d1) * 39'd100;
          ix2  <= ix1;
          if (v2 && pos2) begin
            run100 <= sum;
            if (!lf && (sum > {7'b0, lthr})) begin
              lf   <= 1'b1;
              lbin <= ix2;
            end
            if (!uf && (sum > {7'b0, uthr})) begin
              uf   <= 1'b1;
              ubin <= ix2;
            end
          end
          if (walk_end) begin
            result.status      <= ST_REPORT;
            result.lower_bin   <= lf ? 7'(lbin) : 7'd0;
            result.upper_bin   <= uf ? 7'(ubin) : nact;
            result.total_count <= population;
            done               <= 1'b1;
            state              <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/ihp_checker.sv -----
// port-level checks for the interval histogram, bound to the top level
// depends on ihp_pkg and the defines header
`default_nettype none
`include "interval_histogram_percentile_top_defines.svh"

module ihp_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire ihp_pkg::result_t result
);
  import ihp_pkg::*;

  // an accepted transaction keeps the block busy
  `IHP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept without busy")
  // one result per transaction
  `IHP_ASSERT_NEXT(a_done_single, done, !done, "result repeated")
  // a result finishes the transaction
  `IHP_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
  // a binned sample leaves its bin nonzero
  `IHP_ASSERT_NOW(a_bin_nonzero, done && (result.status == ST_BINNED),
                  result.bin_total != 32'd0, "binned count is zero")

endmodule

bind interval_histogram_percentile_top ihp_checker u_ihp_checker (.*);

`default_nettype wire

// ----- verif/interval_histogram_percentile_top_tb.sv -----
// testbench for the interval histogram with percentile reports
// depends on ihp_pkg and interval_histogram_percentile_top; self-checking against
// an in-bench predictor of bin counts, snapshots and percentile bins
`default_nettype none

module interval_histogram_percentile_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihp_pkg::*;

  localparam int BINS = 64;
  localparam int DRAIN_CYCLES = 2 * BINS + 20;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;
  logic    cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  interval_histogram_percentile_top #(.BINS(BINS)) dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // histogram state mirror
  logic [31:0] bin_count [BINS];
  logic [31:0] bin_snap [BINS];
  logic [31:0] pop, below_cnt, above_cnt, pop_snap, below_snap, above_snap;
  logic signed [31:0] offset_reg;
  logic [19:0] scale_reg;
  logic [15:0] width_reg;
  logic [6:0]  nbins_reg, lpct_reg, upct_reg;

  result_t pending_results [$];
  int errors = 0;
  int sent = 0;
  int reports = 0;
  int binned = 0;
  int out_of_range = 0;
  bit no_idle = 1'b0;

  // fold one accepted transaction into the mirror and queue its outcome
  function automatic void hist_predict(cmd_t c);
    result_t r;
    longint diff, prod, wdt, bin;
    int unsigned n;
    logic [31:0] d, ipop;
    longint unsigned running, lthr, uthr;
    bit lfound, ufound;
    r = '0;
    n = (nbins_reg > BINS) ? BINS : nbins_reg;
    case (c.func)
      FN_INSERT: begin
        diff = longint'(c.sample) - longint'(offset_reg);
        prod = longint'(scale_reg) * diff;
        wdt = (width_reg == 0) ? 64'sd1 : longint'(width_reg);
        bin = prod / wdt;
        pop = pop + 1;
        if (bin < 0) begin
          below_cnt = below_cnt + 1;
          r.status = ST_BELOW;
          out_of_range++;
        end else if (bin >= longint'(n)) begin
          above_cnt = above_cnt + 1;
          r.status = ST_ABOVE;
          out_of_range++;
        end else begin
          bin_count[bin] = bin_count[bin] + 1;
          r.status = ST_BINNED;
          r.bin_total = bin_count[bin];
          binned++;
        end
        r.total_count = pop;
      end
      FN_REPORT: begin
        ipop = pop - pop_snap;
        r.below_delta = below_cnt - below_snap;
        r.above_delta = above_cnt - above_snap;
        pop_snap = pop;
        below_snap = below_cnt;
        above_snap = above_cnt;
        running = 0;
        lthr = longint'(lpct_reg) * longint'(ipop);
        uthr = longint'(upct_reg) * longint'(ipop);
        lfound = 1'b0;
        ufound = 1'b0;
        r.lower_bin = '0;
        r.upper_bin = 7'(n);
        for (int i = 0; i < n; i++) begin
          d = bin_count[i] - bin_snap[i];
          if (d != 0 && !d[31]) begin
            running += d;
            if (!lfound && 100 * running > lthr) begin
              lfound = 1'b1;
              r.lower_bin = 7'(i);
            end
            if (!ufound && 100 * running > uthr) begin
              ufound = 1'b1;
              r.upper_bin = 7'(i);
            end
            bin_snap[i] = bin_count[i];
          end
        end
        r.status = ST_REPORT;
        r.interval_count = ipop;
        r.total_count = pop;
        reports++;
      end
      FN_CLEAR: begin
        foreach (bin_count[i]) bin_count[i] = '0;
        r.status = ST_CLEARED;
        r.total_count = pop;
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker: every strobed transaction against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $realtime, result);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 32'(e.status), 32'(result.status));
        check_field("bin_total", e.bin_total, result.bin_total);
        check_field("interval_count", e.interval_count, result.interval_count);
        check_field("lower_bin", 32'(e.lower_bin), 32'(result.lower_bin));
        check_field("upper_bin", 32'(e.upper_bin), 32'(result.upper_bin));
        check_field("below_delta", e.below_delta, result.below_delta);
        check_field("above_delta", e.above_delta, result.above_delta);
        check_field("total_count", e.total_count, result.total_count);
      end
    end
  end

  // send one transaction, sometimes with a random gap in front of it
  task automatic send_cmd(logic [1:0] f, logic [31:0] s);
    if (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{func: f, sample: s};
    do @(posedge clk); while (busy);
    hist_predict('{func: f, sample: s});
    sent++;
  endtask

  // hold off until all results are in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // write every register while the block is idle
  task automatic set_config(logic signed [31:0] ofs, logic [19:0] scl, logic [15:0] wdt,
                            logic [6:0] nb, logic [6:0] lp, logic [6:0] up);
    logic [31:0] vals [6];
    drain();
    vals = '{ofs, 32'(scl), 32'(wdt), 32'(nb), 32'(lp), 32'(up)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    offset_reg = ofs;
    scale_reg = scl;
    width_reg = wdt;
    nbins_reg = nb;
    lpct_reg = lp;
    upct_reg = up;
  endtask

  // sample aimed near the active bins, sometimes fully random
  function automatic logic [31:0] aimed_sample();
    longint target;
    int unsigned sc;
    if ($urandom_range(99) < 12) return $urandom;
    sc = (scale_reg == 0) ? 1 : scale_reg;
    target = longint'($urandom_range(0, nbins_reg + 4)) * longint'((width_reg == 0) ? 1 : width_reg);
    target = target / sc + longint'(offset_reg) - longint'($urandom_range(0, 1));
    return 32'(target);
  endfunction

  task automatic test_defaults();
    send_cmd(FN_REPORT, 0);          // empty interval
    send_cmd(FN_INSERT, 0);
    send_cmd(FN_INSERT, 63);
    send_cmd(FN_INSERT, 64);
    send_cmd(FN_INSERT, -1);
    send_cmd(FN_INSERT, 32'h8000_0000);
    send_cmd(FN_INSERT, 32'h7fff_ffff);
    send_cmd(FN_INSERT, 0);
    send_cmd(FN_REPORT, 32'hffff_ffff);
    send_cmd(2'd3, 5);               // unused code, no result
    send_cmd(FN_CLEAR, 0);
    send_cmd(FN_INSERT, 7);
    send_cmd(FN_REPORT, 0);          // cleared bins give negative deltas
    send_cmd(FN_REPORT, 0);
  endtask

  task automatic test_config_extremes();
    set_config(32'sh8000_0000, 20'hfffff, 16'hffff, 7'd1, 7'd0, 7'd100);
    send_cmd(FN_INSERT, 32'h7fff_ffff);
    send_cmd(FN_INSERT, 32'h8000_0000);
    send_cmd(FN_REPORT, 0);
    set_config(32'sh7fff_ffff, 20'd0, 16'd0, 7'd0, 7'd127, 7'd127);  // zero scale, width, bins
    send_cmd(FN_INSERT, 32'h8000_0000);
    send_cmd(FN_INSERT, 0);
    send_cmd(FN_REPORT, 0);
    set_config(0, 20'd1, 16'd1, 7'd127, 7'd100, 7'd0);  // bins beyond the store
    send_cmd(FN_INSERT, 63);
    send_cmd(FN_INSERT, 64);
    send_cmd(FN_INSERT, 0);
    send_cmd(FN_REPORT, 0);
  endtask

  task automatic test_random(int items);
    int f;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        set_config(0, 20'd1, 16'd1, 7'd64, 7'd5, 7'd95);
      else
        set_config($urandom, ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 9)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20)),
                   7'($urandom_range(1, 70)), 7'($urandom_range(0, 100)),
                   7'($urandom_range(0, 100)));
      no_idle = (ph == 3);
      for (int i = 0; i < items / 8; i++) begin
        f = $urandom_range(99);
        if (f < 84) send_cmd(FN_INSERT, aimed_sample());
        else if (f < 95) send_cmd(FN_REPORT, $urandom);
        else if (f < 98) send_cmd(FN_CLEAR, $urandom);
        else send_cmd(2'd3, $urandom);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    foreach (bin_count[i]) begin
      bin_count[i] = '0;
      bin_snap[i] = '0;
    end
    {pop, below_cnt, above_cnt, pop_snap, below_snap, above_snap} = '0;
    offset_reg = 0;
    scale_reg = 20'd1;
    width_reg = 16'd1;
    nbins_reg = 7'd64;
    lpct_reg = 7'd5;
    upct_reg = 7'd95;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_random(1400);
    drain();
    $display("covered %0d transactions: %0d binned, %0d out of range, %0d reports",
             sent, binned, out_of_range, reports);
    if (errors == 0)
      $display("interval_histogram_percentile_top: match");
    else
      $display("interval_histogram_percentile_top: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("interval_histogram_percentile_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
